// ===== design/sus_pkg.sv =====
// Shared types and codes for the sorted unique set.
`default_nettype none
package sus_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VAL_W        = 32;
  localparam int STAT_W       = 2;
  localparam int COUNT_W      = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                    capture;
    logic                    ins_en;
    logic                    rem_en;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== design/sorted_unique_set.sv =====
// Top level of the sorted unique set: controller and the chain of cells.
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one per cell.
// Each request beat (func 0 insert, 1 remove) yields one response beat with a status
// and the count held afterward (low 5 bits). On accept, every cell latches its
// less-than and equal flags against the value; the apply step then settles the one-step
// shift across the chain and loads the response register. If the previous response
// has not yet been taken, the item waits before that apply step.
`default_nettype none
module sorted_unique_set #(
  parameter int CAPACITY = sus_pkg::DEF_CAPACITY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic                             func,
  input  wire logic signed [sus_pkg::VAL_W-1:0] value,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic [sus_pkg::STAT_W-1:0]            status,
  output logic [sus_pkg::COUNT_W-1:0]           count
);
  import sus_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                    busy;
  logic                    op_func;
  logic signed [VAL_W-1:0] op_value;
  logic [CNT_W-1:0]        held;
  logic [CNT_W-1:0]        held_next;
  status_t                 stat_next;
  logic                    apply;
  logic                    hit;
  logic                    full;
  logic [CNT_W+COUNT_W-1:0] held_ext;
  cell_cmd_t               cmd;

  logic [CAPACITY-1:0]     lt_v;
  logic [CAPACITY-1:0]     eq_v;
  logic signed [VAL_W-1:0] val_v [CAPACITY];

  assign req_ready = !busy;
  assign apply     = busy && (!rsp_valid || rsp_ready);
  assign hit       = |eq_v;
  assign full      = held == CNT_W'(CAPACITY);

  always_comb begin
    cmd.capture = req_valid && req_ready;
    cmd.ins_en  = apply && (op_func == FUNC_INSERT) && !hit && !full;
    cmd.rem_en  = apply && (op_func == FUNC_REMOVE) && hit;
    cmd.value   = busy ? op_value : value;
  end

  always_comb begin
    held_next = held;
    stat_next = STAT_DONE;
    case (func_t'(op_func))
      FUNC_INSERT: begin
        if (hit) begin
          stat_next = STAT_DUP;
        end else if (full) begin
          stat_next = STAT_FULL;
        end else begin
          held_next = held + CNT_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          held_next = held - CNT_W'(1);
        end else begin
          stat_next = STAT_NOTFOUND;
        end
      end
      default: begin
        stat_next = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      held      <= '0;
    end else begin
      if (cmd.capture) begin
        busy     <= 1'b1;
        op_func  <= func;
        op_value <= value;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (apply) begin
        busy      <= 1'b0;
        held      <= held_next;
        rsp_valid <= 1'b1;
        status    <= stat_next;
      end
    end
  end

  assign held_ext = {{COUNT_W{1'b0}}, held};
  assign count    = held_ext[COUNT_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = val_v[i];
    end else begin : g_mid
      assign left_lt  = lt_v[i-1];
      assign left_val = val_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = val_v[i];
    end else begin : g_inner
      assign right_val = val_v[i+1];
    end

    sus_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .held      (held),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (lt_v[i]),
      .eq        (eq_v[i]),
      .val       (val_v[i])
    );
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in flight");

  a_count_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(held) |-> rsp_valid && status == STAT_DONE)
    else $error("count changed without a done response");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_FULL |-> held == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(eq_v))
    else $error("value held in more than one cell");

endmodule
`default_nettype wire

// ===== design/sus_cell.sv =====
// One slot of the sorted chain: compare against the broadcast value, shift with neighbors.
`default_nettype none
module sus_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                            clk,
  input  wire sus_pkg::cell_cmd_t              cmd,
  input  wire logic [CNT_W-1:0]                held,
  input  wire logic                            left_lt,
  input  wire logic signed [sus_pkg::VAL_W-1:0] left_val,
  input  wire logic signed [sus_pkg::VAL_W-1:0] right_val,
  output logic                                 lt,
  output logic                                 eq,
  output logic signed [sus_pkg::VAL_W-1:0]     val
);
  import sus_pkg::*;

  logic occupied;

  assign occupied = held > CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lt <= occupied && (val < cmd.value);
      eq <= occupied && (val == cmd.value);
    end
    // Cells at or past the slot open a gap or close one.
    if (cmd.ins_en && !lt) begin
      val <= left_lt ? cmd.value : left_val;
    end else if (cmd.rem_en && !lt) begin
      val <= right_val;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the sorted unique set: table-driven and random insert/remove beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sus_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 350;
  localparam int POOL_SIZE   = 24;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    status_t              st;
    logic [COUNT_W-1:0]   cnt;
  } set_rsp_t;

  typedef struct {
    bit       pinned;
    set_rsp_t rsp;
  } pin_t;

  typedef struct {
    func_t                   op;
    logic signed [VAL_W-1:0] v;
    bit                      pinned;
    status_t                 st;
    logic [COUNT_W-1:0]      cnt;
  } stim_row_t;

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  logic                      func;
  logic signed [VAL_W-1:0]   value;
  logic                      rsp_valid;
  logic                      rsp_ready;
  logic [STAT_W-1:0]         rsp_status;
  logic [COUNT_W-1:0]        rsp_cnt;

  sorted_unique_set i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .func      (func),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (rsp_status),
    .count     (rsp_cnt)
  );

  // Shadow copy of the set contents.
  logic signed [VAL_W-1:0] shadow_vals [CAP];
  int                      shadow_held = 0;

  set_rsp_t                expected_q [$];
  pin_t                    pin_q [$];
  logic signed [VAL_W-1:0] pool [POOL_SIZE];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int beats_sent    = 0;
  int beats_answered = 0;
  int mismatches    = 0;
  int n_done = 0, n_dup = 0, n_notfound = 0, n_full = 0;

  stim_row_t directed_rows [0:24] = '{
    '{FUNC_REMOVE, 32'h0000_0000, 1'b1, STAT_NOTFOUND, 5'd0},
    '{FUNC_INSERT, 32'h8000_0000, 1'b1, STAT_DONE,     5'd1},
    '{FUNC_INSERT, 32'h8000_0000, 1'b1, STAT_DUP,      5'd1},
    '{FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_DONE,     5'd2},
    '{FUNC_INSERT, 32'h0000_0000, 1'b1, STAT_DONE,     5'd3},
    '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_DONE,     5'd4},
    '{FUNC_REMOVE, 32'h0000_0001, 1'b1, STAT_NOTFOUND, 5'd4},
    '{FUNC_REMOVE, 32'h7FFF_FFFF, 1'b1, STAT_DONE,     5'd3},
    '{FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_DONE,     5'd4},
    '{FUNC_INSERT, 32'h4000_0000, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'hC000_0000, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h0000_0001, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'hFFFF_FFFE, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h7FFF_FFFE, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h8000_0001, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h1234_5678, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'hEDCB_A988, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h0000_FFFF, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'hFFFF_0000, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h5555_5555, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, STAT_DONE,     5'd0},
    '{FUNC_INSERT, 32'h0000_0002, 1'b1, STAT_FULL,     5'd16},
    '{FUNC_INSERT, 32'h0000_0000, 1'b1, STAT_DUP,      5'd16},
    '{FUNC_REMOVE, 32'h8000_0000, 1'b1, STAT_DONE,     5'd15},
    '{FUNC_REMOVE, 32'h0000_0002, 1'b1, STAT_NOTFOUND, 5'd15}
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one operation to the shadow set and return the response it gives.
  function automatic set_rsp_t apply_set_op(func_t op, logic signed [VAL_W-1:0] v);
    set_rsp_t r;
    int       pos;
    bit       hit;
    pos = 0;
    while (pos < shadow_held && shadow_vals[pos] < v) pos++;
    hit = (pos < shadow_held) && (shadow_vals[pos] == v);
    if (op == FUNC_INSERT) begin
      if (hit) begin
        r.st = STAT_DUP;
      end else if (shadow_held >= CAP) begin
        r.st = STAT_FULL;
      end else begin
        for (int j = shadow_held; j > pos; j--) shadow_vals[j] = shadow_vals[j-1];
        shadow_vals[pos] = v;
        shadow_held++;
        r.st = STAT_DONE;
      end
    end else begin
      if (hit) begin
        for (int j = pos; j + 1 < shadow_held; j++) shadow_vals[j] = shadow_vals[j+1];
        shadow_held--;
        r.st = STAT_DONE;
      end else begin
        r.st = STAT_NOTFOUND;
      end
    end
    r.cnt = COUNT_W'(shadow_held);
    return r;
  endfunction

  // Accept side predicts, response side checks against the oldest expectation.
  always @(posedge clk) begin
    pin_t     pin;
    set_rsp_t pred;
    set_rsp_t exp_rsp;
    if (!rst) begin
      if (req_valid && req_ready) begin
        pin  = pin_q.pop_front();
        pred = apply_set_op(func_t'(func), value);
        expected_q.push_back(pin.pinned ? pin.rsp : pred);
      end
      if (rsp_valid && rsp_ready) begin
        beats_answered++;
        case (status_t'(rsp_status))
          STAT_DONE:     n_done++;
          STAT_DUP:      n_dup++;
          STAT_NOTFOUND: n_notfound++;
          STAT_FULL:     n_full++;
          default: ;
        endcase
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("response beat with nothing expected: status %0d count %0d",
                 rsp_status, rsp_cnt);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_status !== exp_rsp.st) begin
            mismatches++;
            $error("status: expected %0d, got %0d", exp_rsp.st, rsp_status);
          end
          if (rsp_cnt !== exp_rsp.cnt) begin
            mismatches++;
            $error("count: expected %0d, got %0d", exp_rsp.cnt, rsp_cnt);
          end
        end
      end
    end
  end

  // Response side: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin : rsp_side
    int seen_seq;
    int hold_left;
    seen_seq  = 0;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL sorted_unique_set");
    $finish;
  end

  task automatic send_beat(func_t op, logic signed [VAL_W-1:0] v, pin_t pin);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= op;
    value     <= v;
    pin_q.push_back(pin);
    do @(posedge clk); while (!req_ready);
    beats_sent++;
  endtask

  // Drop valid and wait for every outstanding response.
  task automatic drain_set();
    req_valid <= 1'b0;
    wait (beats_answered == beats_sent);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 65) return pool[$urandom_range(POOL_SIZE-1)];
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    pin_t  pin;
    int    ins_bias;
    int    idle_set [4];
    int    stall_set [4];
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = 1'b0;
    value     = '0;
    idle_set  = '{0, 85, 0, 13};
    stall_set = '{0, 0, 85, 13};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pin.pinned  = directed_rows[i].pinned;
      pin.rsp.st  = directed_rows[i].st;
      pin.rsp.cnt = directed_rows[i].cnt;
      send_beat(directed_rows[i].op, directed_rows[i].v, pin);
    end
    drain_set();

    pin.pinned = 1'b0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      foreach (pool[k]) pool[k] = $urandom;
      pool[0] = VAL_MIN;
      pool[1] = VAL_MAX;
      ins_bias = 80;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Swing between filling toward full and draining toward empty.
        if (n % 50 == 0) ins_bias = (ins_bias == 80) ? 25 : 80;
        if (p == 0 && n == 150) hold_seq++;
        send_beat(($urandom_range(99) < ins_bias) ? FUNC_INSERT : FUNC_REMOVE,
                  pick_value(), pin);
        if (p == 2 && n == 200) drain_set();
      end
      drain_set();
    end

    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      $error("%0d expected responses never arrived", expected_q.size());
    $display("Ran %0d insert/remove beats under four idle/stall mixes and a long hold-off.",
             beats_sent);
    $display("Statuses seen: %0d done, %0d duplicate, %0d not found, %0d full.",
             n_done, n_dup, n_notfound, n_full);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS sorted_unique_set");
    end else begin
      $display("FAIL sorted_unique_set");
    end
    $finish;
  end

endmodule
